[sv/bdse_pkg.sv]
// Shared types, constants and helpers for the battery drain slope estimator.
// No dependencies.
package bdse_pkg;

    localparam int WINDOW_DEPTH = 32;
    localparam int SLOT_W = (WINDOW_DEPTH > 2) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);

    // x is whole seconds of a 32-bit ms difference, y a 0..100 charge
    localparam int X_W   = 23;
    localparam int Y_W   = 7;
    localparam int SX_W  = X_W + CNT_W;
    localparam int SY_W  = Y_W + CNT_W;
    localparam int SXX_W = 2 * X_W + CNT_W;
    localparam int SXY_W = X_W + Y_W + CNT_W;
    localparam int DEN_W = SXX_W + CNT_W;
    localparam int D_W   = SX_W + SY_W;
    localparam int DIV_W = DEN_W + Y_W + 1;

    // floor(2^38 / 1000), low by under one unit of the quotient
    localparam logic [28:0] RECIP_1000 = 29'd274877906;
    localparam int          RECIP_SH   = 38;

    localparam logic [31:0] INTERVAL_RST = 32'd300000;
    localparam logic [31:0] SPAN_RST     = 32'd1800000;

    localparam logic CFG_INTERVAL = 1'b0;
    localparam logic CFG_SPAN     = 1'b1;

    typedef struct packed {
        logic [31:0]       now_ms;
        logic              has_battery;
        logic              on_usb;
        logic signed [7:0] charge_percent;
    } t_in;

    typedef struct packed {
        logic        estimate_valid;
        logic [15:0] drain_tenths_per_hour;
        logic [31:0] minutes_left;
        logic [5:0]  window_count;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE, S_CHK, S_EST0, S_EST1, S_EST2, S_WALK,
        S_FIN1, S_FIN2, S_FIN3, S_FIN4, S_DIV, S_OUT
    } t_state;

    // (base + k) mod WINDOW_DEPTH, with base < depth and k <= depth
    function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] base,
                                                   input logic [CNT_W-1:0] k);
        logic [SLOT_W+1:0] sum;
        sum = (SLOT_W + 2)'(base) + (SLOT_W + 2)'(k);
        if (sum >= (SLOT_W + 2)'(WINDOW_DEPTH)) begin
            sum = sum - (SLOT_W + 2)'(WINDOW_DEPTH);
        end
        return sum[SLOT_W-1:0];
    endfunction

endpackage

[sv/bdse_div.sv]
// Restoring divider, one quotient bit per cycle.
// Depends on bdse_pkg.
module bdse_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [bdse_pkg::DIV_W-1:0]  i_num,
    input  logic [bdse_pkg::DIV_W-1:0]  i_den,
    output logic                        o_done,
    output logic [bdse_pkg::DIV_W-1:0]  o_quo
);
    import bdse_pkg::*;

    localparam int CW = $clog2(DIV_W + 1);

    logic [DIV_W:0]   r_rem;
    logic [DIV_W-1:0] r_quo;
    logic [DIV_W-1:0] r_den;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DIV_W:0] rem_sh;
    logic           fits;

    assign rem_sh = {r_rem[DIV_W-1:0], r_quo[DIV_W-1]};
    assign fits   = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_num;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= fits ? rem_sh - {1'b0, r_den} : rem_sh;
                r_quo <= {r_quo[DIV_W-2:0], fits};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

[sv/battery_drain_slope_estimator.sv]
// Battery drain slope estimator top level: sample ring in two memories,
// least-squares walk, result sequencer. Depends on bdse_pkg and bdse_div.
//
//  channel  | handshake                     | payload
//  ---------+-------------------------------+-------------------
//  input    | i_in_valid / o_in_stall       | i_in  (t_in)
//  output   | o_out_valid / i_out_stall     | o_out (t_out)
//  config   | i_cfg_we                      | i_cfg_index, i_cfg_data
//
// One transaction at a time; the serial divider sets most of its length.
// Invalid cases leave early.
// Synchronous active-low reset; no clearing pass, entries are read only once written.
// A result waiting under i_out_stall holds the sequencer at its final step only.
module battery_drain_slope_estimator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  bdse_pkg::t_in      i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output bdse_pkg::t_out     o_out,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    import bdse_pkg::*;

    logic [31:0]    mem_t [WINDOW_DEPTH];
    logic [Y_W-1:0] mem_c [WINDOW_DEPTH];

    t_state r_state, n_state;

    logic [31:0]       r_interval, r_span;
    logic [SLOT_W-1:0] r_oldest;
    logic [CNT_W-1:0]  r_held;
    logic [31:0]       r_now;
    logic [Y_W-1:0]    r_soc;
    logic              r_void;
    logic [31:0]       r_rd_t;
    logic [Y_W-1:0]    r_rd_c;
    logic [31:0]       r_t0;
    logic [Y_W-1:0]    r_cn;
    logic [CNT_W-1:0]  r_widx;
    logic [SLOT_W-1:0] r_wslot;

    logic              r_v0, r_v1, r_v2, r_v3, r_v4, r_v5;
    logic [31:0]       r_dt1, r_dt2;
    logic [Y_W-1:0]    r_y1, r_y2, r_y3, r_y4;
    logic [60:0]       r_p;
    logic [X_W-1:0]    r_q0, r_x4, r_x5;
    logic [10:0]       r_rem;
    logic [2*X_W-1:0]  r_xx;
    logic [X_W+Y_W-1:0] r_xy;
    logic [Y_W-1:0]    r_y5;

    logic [SX_W-1:0]  r_sx;
    logic [SY_W-1:0]  r_sy;
    logic [SXX_W-1:0] r_sxx;
    logic [SXY_W-1:0] r_sxy;
    logic [DEN_W-1:0] r_nsxx, r_sx2, r_den;
    logic [D_W-1:0]   r_sxsy, r_nsxy, r_d;
    logic [D_W+16:0]  r_t72;
    logic [D_W+5:0]   r_m;
    logic [DEN_W+Y_W-1:0] r_cden;

    logic        r_ok;
    logic [15:0] r_tenths;
    logic [31:0] r_minutes;
    logic        r_out_valid;
    t_out        r_out;

    // control decode
    logic              in_acc, rd_en, wr_en, div_start, out_load, issue, pipe_busy;
    logic [SLOT_W-1:0] rd_addr, wr_addr, newest;
    logic              chk_break, chk_skip, chk_full;
    logic [Y_W-1:0]    soc_c;
    logic              span_short;
    logic              div_done1, div_done2;
    logic [DIV_W-1:0]  quo1, quo2;
    logic [DIV_W-1:0]  num1, den1, num2, den2;

    assign in_acc    = i_in_valid && !o_in_stall;
    assign newest    = slot_add(r_oldest, r_held - 1'b1);
    assign issue     = r_widx < r_held;
    assign pipe_busy = r_v0 | r_v1 | r_v2 | r_v3 | r_v4 | r_v5;
    assign chk_break = (r_held != '0) &&
                       ((r_now < r_rd_t) || ({1'b0, r_soc} > ({1'b0, r_rd_c} + 1'b1)));
    assign chk_skip  = (r_held != '0) && !chk_break && ((r_now - r_rd_t) < r_interval);
    assign chk_full  = r_held == CNT_W'(WINDOW_DEPTH);
    assign span_short = (r_rd_t - r_t0) < r_span;

    always_comb begin
        if (i_in.charge_percent[7]) begin
            soc_c = '0;
        end else if (i_in.charge_percent > 8'sd100) begin
            soc_c = Y_W'(100);
        end else begin
            soc_c = i_in.charge_percent[Y_W-1:0];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_acc) n_state = (!i_in.has_battery || i_in.on_usb) ? S_EST0 : S_CHK;
            S_CHK:  n_state = S_EST0;
            S_EST0: n_state = (r_held < CNT_W'(2)) ? S_OUT : S_EST1;
            S_EST1: n_state = S_EST2;
            S_EST2: n_state = span_short ? S_OUT : S_WALK;
            S_WALK: if (!issue && !pipe_busy) n_state = S_FIN1;
            S_FIN1: n_state = S_FIN2;
            S_FIN2: n_state = (r_nsxx <= r_sx2 || r_sxsy <= r_nsxy) ? S_OUT : S_FIN3;
            S_FIN3: n_state = S_FIN4;
            S_FIN4: n_state = (r_t72 < (D_W + 17)'(r_den)) ? S_OUT : S_DIV;
            S_DIV:  if (div_done1 && div_done2) n_state = S_OUT;
            S_OUT:  if (!r_out_valid || !i_out_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_in_stall = 1'b1;
        rd_en      = 1'b0;
        rd_addr    = newest;
        wr_en      = 1'b0;
        wr_addr    = slot_add(r_oldest, r_held);
        div_start  = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                rd_en      = 1'b1;
            end
            S_CHK: begin
                wr_en = !chk_skip;
                if (chk_break || chk_full) begin
                    wr_addr = r_oldest;
                end
            end
            S_EST0: begin
                rd_en   = 1'b1;
                rd_addr = r_oldest;
            end
            S_EST1: rd_en = 1'b1;
            S_WALK: begin
                rd_en   = issue;
                rd_addr = r_wslot;
            end
            S_FIN4: div_start = !(r_t72 < (D_W + 17)'(r_den));
            S_OUT:  out_load  = !r_out_valid || !i_out_stall;
            default: ;
        endcase
    end

    assign num1 = DIV_W'(r_t72) + DIV_W'(r_den);
    assign den1 = DIV_W'({r_den, 1'b0});
    assign num2 = DIV_W'(r_cden);
    assign den2 = DIV_W'(r_m);

    bdse_div u_div_rate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num1),
        .i_den   (den1),
        .o_done  (div_done1),
        .o_quo   (quo1)
    );

    bdse_div u_div_left (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num2),
        .i_den   (den2),
        .o_done  (div_done2),
        .o_quo   (quo2)
    );

    // sample memories
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_t[wr_addr] <= r_now;
            mem_c[wr_addr] <= r_soc;
        end
        if (rd_en) begin
            r_rd_t <= mem_t[rd_addr];
            r_rd_c <= mem_c[rd_addr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_interval  <= INTERVAL_RST;
            r_span      <= SPAN_RST;
            r_oldest    <= '0;
            r_held      <= '0;
            r_out_valid <= 1'b0;
            r_v0 <= 1'b0; r_v1 <= 1'b0; r_v2 <= 1'b0;
            r_v3 <= 1'b0; r_v4 <= 1'b0; r_v5 <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_INTERVAL: r_interval <= i_cfg_data;
                    CFG_SPAN:     r_span     <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == S_IDLE && in_acc && (!i_in.has_battery || i_in.on_usb)) begin
                r_held <= '0;
            end
            if (r_state == S_CHK && !chk_skip) begin
                if (chk_break) begin
                    r_held <= CNT_W'(1);
                end else if (chk_full) begin
                    r_oldest <= slot_add(r_oldest, CNT_W'(1));
                end else begin
                    r_held <= r_held + 1'b1;
                end
            end
            r_v0 <= (r_state == S_WALK) && issue;
            r_v1 <= r_v0; r_v2 <= r_v1; r_v3 <= r_v2; r_v4 <= r_v3; r_v5 <= r_v4;
            if (o_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && in_acc) begin
            r_now  <= i_in.now_ms;
            r_soc  <= soc_c;
            r_void <= !i_in.has_battery || i_in.on_usb;
            r_ok   <= 1'b0;
        end
        if (r_state == S_EST1) begin
            r_t0 <= r_rd_t;
        end
        if (r_state == S_EST2) begin
            r_cn    <= r_rd_c;
            r_widx  <= '0;
            r_wslot <= r_oldest;
            r_sx    <= '0;
            r_sy    <= '0;
            r_sxx   <= '0;
            r_sxy   <= '0;
        end
        if (r_state == S_WALK && issue) begin
            r_widx  <= r_widx + 1'b1;
            r_wslot <= slot_add(r_wslot, CNT_W'(1));
        end
        // x = (t - t0) / 1000 through a reciprocal with one correction
        r_dt1 <= r_rd_t - r_t0;
        r_y1  <= r_rd_c;
        r_p   <= 61'(r_dt1) * 61'(RECIP_1000);
        r_dt2 <= r_dt1;
        r_y2  <= r_y1;
        r_q0  <= r_p[RECIP_SH +: X_W];
        r_rem <= 11'(r_dt2 - 32'(r_p[RECIP_SH +: X_W]) * 32'd1000);
        r_y3  <= r_y2;
        r_x4  <= r_q0 + X_W'(r_rem >= 11'd1000);
        r_y4  <= r_y3;
        r_xx  <= (2 * X_W)'(r_x4) * (2 * X_W)'(r_x4);
        r_xy  <= (X_W + Y_W)'(r_x4) * (X_W + Y_W)'(r_y4);
        r_x5  <= r_x4;
        r_y5  <= r_y4;
        if (r_v5) begin
            r_sx  <= r_sx + SX_W'(r_x5);
            r_sy  <= r_sy + SY_W'(r_y5);
            r_sxx <= r_sxx + SXX_W'(r_xx);
            r_sxy <= r_sxy + SXY_W'(r_xy);
        end
        if (r_state == S_FIN1) begin
            r_nsxx <= DEN_W'(r_held) * DEN_W'(r_sxx);
            r_sx2  <= DEN_W'(r_sx) * DEN_W'(r_sx);
            r_sxsy <= D_W'(r_sx) * D_W'(r_sy);
            r_nsxy <= D_W'(r_held) * D_W'(r_sxy);
        end
        if (r_state == S_FIN2) begin
            r_den <= r_nsxx - r_sx2;
            r_d   <= r_sxsy - r_nsxy;
        end
        if (r_state == S_FIN3) begin
            r_t72  <= (D_W + 17)'(r_d) * (D_W + 17)'(72000);
            r_m    <= (D_W + 6)'(r_d) * (D_W + 6)'(60);
            r_cden <= (DEN_W + Y_W)'(r_cn) * (DEN_W + Y_W)'(r_den);
        end
        if (r_state == S_DIV && div_done1) begin
            r_ok      <= 1'b1;
            r_tenths  <= (quo1 > DIV_W'(16'hFFFF)) ? 16'hFFFF : quo1[15:0];
            r_minutes <= (quo2 > DIV_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : quo2[31:0];
        end
        if (out_load) begin
            r_out.estimate_valid        <= r_ok && !r_void;
            r_out.drain_tenths_per_hour <= (r_ok && !r_void) ? r_tenths : 16'd0;
            r_out.minutes_left          <= (r_ok && !r_void) ? r_minutes : 32'd0;
            r_out.window_count          <= 6'(r_held);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
